[sv/ptr_pkg.sv]
// Shared types and constants for the programmable timer with reload.
`timescale 1ns / 1ps

package ptr_pkg;

	localparam int unsigned PRESCALE_W = 10;

	// Request kinds
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Register addresses
	localparam logic [1:0] ADDR_COUNT   = 2'd0;
	localparam logic [1:0] ADDR_RELOAD  = 2'd1;
	localparam logic [1:0] ADDR_CONTROL = 2'd2;

	localparam int unsigned ENABLE_BIT = 2;
	localparam logic [7:0]  COUNT_MAX  = 8'hFF;

	// Prescaler periods selected by control bits 1:0
	localparam logic [PRESCALE_W:0] PERIOD_SEL0 = 11'd1024;
	localparam logic [PRESCALE_W:0] PERIOD_SEL1 = 11'd16;
	localparam logic [PRESCALE_W:0] PERIOD_SEL2 = 11'd64;
	localparam logic [PRESCALE_W:0] PERIOD_SEL3 = 11'd256;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_request;
	} result_t;

	function automatic logic [PRESCALE_W:0] period_of(input logic [1:0] sel);
		logic [PRESCALE_W:0] p;
		case (sel)
			2'd0:    p = PERIOD_SEL0;
			2'd1:    p = PERIOD_SEL1;
			2'd2:    p = PERIOD_SEL2;
			default: p = PERIOD_SEL3;
		endcase
		return p;
	endfunction

endpackage

[sv/ptr_core.sv]
// Timer register file, prescaler and counter update for one word per cycle while accept is high.
`timescale 1ns / 1ps

module ptr_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         req_type,
	input  logic [1:0]         reg_addr,
	input  logic [7:0]         write_data,
	output ptr_pkg::result_t   result
);

	logic [7:0]                    count_q;
	logic [7:0]                    reload_q;
	logic [7:0]                    control_q;
	logic [ptr_pkg::PRESCALE_W-1:0] prescale_q;

	logic [7:0]                    count_d;
	logic [7:0]                    control_d;
	logic [7:0]                    reload_d;
	logic [ptr_pkg::PRESCALE_W-1:0] prescale_d;
	logic [ptr_pkg::PRESCALE_W:0]   pre_inc;
	logic [ptr_pkg::PRESCALE_W:0]   period;
	logic [ptr_pkg::PRESCALE_W:0]   pre_sub;

	always_comb begin
		count_d    = count_q;
		reload_d   = reload_q;
		control_d  = control_q;
		prescale_d = prescale_q;
		result     = '0;
		period     = ptr_pkg::period_of(control_q[1:0]);
		pre_inc    = {1'b0, prescale_q} + 1'b1;
		pre_sub    = pre_inc - period;
		case (req_type)
			ptr_pkg::REQ_TICK: begin
				if (control_q[ptr_pkg::ENABLE_BIT]) begin
					prescale_d = pre_inc[ptr_pkg::PRESCALE_W-1:0];
					if (pre_inc >= period) begin
						// one period per tick; any excess drains on later ticks
						prescale_d = pre_sub[ptr_pkg::PRESCALE_W-1:0];
						if (count_q == ptr_pkg::COUNT_MAX) begin
							count_d            = reload_q;
							result.irq_request = 1'b1;
						end else begin
							count_d = count_q + 8'd1;
						end
					end
				end
			end
			ptr_pkg::REQ_WRITE: begin
				unique case (reg_addr)
					ptr_pkg::ADDR_COUNT:  count_d  = write_data;
					ptr_pkg::ADDR_RELOAD: reload_d = write_data;
					ptr_pkg::ADDR_CONTROL: begin
						// rising enable restarts the prescaler and loads the counter
						if (write_data[ptr_pkg::ENABLE_BIT] &&
						    !control_q[ptr_pkg::ENABLE_BIT]) begin
							prescale_d = '0;
							count_d    = reload_q;
						end
						control_d = write_data;
					end
					default: ;
				endcase
			end
			ptr_pkg::REQ_READ: begin
				unique case (reg_addr)
					ptr_pkg::ADDR_COUNT:   result.read_data = count_q;
					ptr_pkg::ADDR_RELOAD:  result.read_data = reload_q;
					ptr_pkg::ADDR_CONTROL: result.read_data = control_q;
					default:               result.read_data = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			reload_q   <= '0;
			control_q  <= '0;
			prescale_q <= '0;
		end else if (accept) begin
			count_q    <= count_d;
			reload_q   <= reload_d;
			control_q  <= control_d;
			prescale_q <= prescale_d;
		end
	end

endmodule

[sv/programmable_timer_with_reload.sv]
// Top level of the programmable 8-bit timer with reload and interrupt pulse.
`timescale 1ns / 1ps

// Programmable 8-bit timer with counter, reload and control registers. Every word on the
// input channel is a tick of one CPU clock, a register write or a register read, and
// each gives exactly one result word: read_data (register value on a read, else zero)
// and irq_request (counter overflow on this tick). One word is taken every cycle while
// in_stall is low; the register update is combinational from the input to the state
// registers, and the result leaves through an output register backed by one skid entry,
// so in_stall is a register and rises only after the output side has stalled two words.
module programmable_timer_with_reload (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [1:0] reg_addr,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       irq_request
);

	ptr_pkg::result_t result;
	ptr_pkg::result_t out_q;
	ptr_pkg::result_t skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;
	logic             accept;
	logic             out_free;

	assign in_stall    = skid_valid_q;
	assign accept      = in_valid && !skid_valid_q;
	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign read_data   = out_q.read_data;
	assign irq_request = out_q.irq_request;

	ptr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req_type   (req_type),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				// advance skid into output, else take the new word
				out_valid_q <= skid_valid_q || accept;
				if (skid_valid_q)
					skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= result;
		end
		if (accept && !out_free)
			skid_q <= result;
	end

endmodule
